[hdl/assert_macros.svh]
// assertion macros shared by the rtl
// each macro is empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// clocked property that is ignored while reset is high
`define UTF8D_ASSERT_RST(lbl, clk, rst, prop) \
lbl: assert property (@(posedge clk) disable iff (rst) prop) \
   else $error("utf8d assertion failed");

// clocked property that is checked through reset as well
`define UTF8D_ASSERT(lbl, clk, prop) \
lbl: assert property (@(posedge clk) prop) \
   else $error("utf8d assertion failed");

`else

`define UTF8D_ASSERT_RST(lbl, clk, rst, prop)
`define UTF8D_ASSERT(lbl, clk, prop)

`endif

`endif

[hdl/utf8d_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types, constants and helper functions of the utf-8 stream decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

   localparam logic [7:0]  LEAD2_LO     = 8'hC2;
   localparam logic [7:0]  LEAD2_HI     = 8'hDF;
   localparam logic [7:0]  LEAD3_LO     = 8'hE0;
   localparam logic [7:0]  LEAD3_HI     = 8'hEF;
   localparam logic [7:0]  LEAD3_SURR   = 8'hED;
   localparam logic [7:0]  LEAD4_LO     = 8'hF0;
   localparam logic [7:0]  LEAD4_HI     = 8'hF4;
   localparam logic [7:0]  CONT_A0      = 8'hA0;
   localparam logic [7:0]  CONT_90      = 8'h90;
   localparam logic [7:0]  CONT_8F      = 8'h8F;
   localparam logic [20:0] REPL_CP      = 21'h00FFFD;
   localparam logic [20:0] NBSP_CP      = 21'h0000A0;
   localparam logic [20:0] MAX_CP       = 21'h10FFFF;
   localparam logic [6:0]  CON_UNKNOWN  = 7'h3F;
   localparam logic [6:0]  CON_SPACE    = 7'h20;

   // what one accepted byte leaves for the result side:
   // rep_cnt replacements first, then the decoded code point if has_cp
   typedef struct packed {
      logic [2:0]  rep_cnt;
      logic        has_cp;
      logic [20:0] cp;
      logic [6:0]  con;
   } utf8d_job_type;

   // sequence length announced by a lead byte, zero when not a lead
   function automatic logic [2:0] seq_need(input logic [7:0] lead);
      logic [2:0] need;
      need = 3'd0;
      if (lead inside {[LEAD2_LO:LEAD2_HI]}) begin
         need = 3'd2;
      end else if (lead inside {[LEAD3_LO:LEAD3_HI]}) begin
         need = 3'd3;
      end else if (lead inside {[LEAD4_LO:LEAD4_HI]}) begin
         need = 3'd4;
      end
      return need;
   endfunction

   // 7-bit console form of a code point
   function automatic logic [6:0] console_form(input logic [20:0] cp);
      logic [6:0] con;
      con = CON_UNKNOWN;
      if (cp inside {21'h1B, 21'h0A, 21'h0D, 21'h08, 21'h09, [21'h20:21'h7E]}) begin
         con = cp[6:0];
      end else if (cp == NBSP_CP) begin
         con = CON_SPACE;
      end
      return con;
   endfunction

endpackage

[hdl/utf8d_decode.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_decode
// Next-state and result logic for one byte against the held sequence.
// ----------------------------------------------------------------------------
module utf8d_decode import utf8d_pkg::*; (
   input  logic [7:0]      data_byte,
   input  logic            end_of_text,
   input  logic [1:0]      held_cnt,
   input  logic [2:0][7:0] held_bytes,
   output logic [1:0]      held_cnt_next,
   output logic [2:0][7:0] held_bytes_next,
   output utf8d_job_type   job
);

   logic [7:0]  lead;
   logic [2:0]  need;
   logic [2:0]  pos;
   logic        restricted;
   logic        cont_good;
   logic        ok;
   logic        complete;
   logic [20:0] cp_seq;
   logic        fresh;

   assign lead = held_bytes[0];
   assign need = seq_need(lead);
   assign pos  = {1'b0, held_cnt};

   // limits on the second byte against overlong, surrogate and out of range
   assign restricted = (lead == LEAD3_LO   && data_byte <  CONT_A0) ||
                       (lead == LEAD3_SURR && data_byte >= CONT_A0) ||
                       (lead == LEAD4_LO   && data_byte <  CONT_90) ||
                       (lead == LEAD4_HI   && data_byte >  CONT_8F);

   assign cont_good = (data_byte[7:6] == 2'b10) && !(held_cnt == 2'd1 && restricted);
   assign complete  = (pos + 3'd1 == need);

   always_comb begin
      case (need)
         3'd2:    cp_seq = {10'd0, lead[4:0], data_byte[5:0]};
         3'd3:    cp_seq = {5'd0, lead[3:0], held_bytes[1][5:0], data_byte[5:0]};
         3'd4:    cp_seq = {lead[2:0], held_bytes[1][5:0], held_bytes[2][5:0],
                            data_byte[5:0]};
         default: cp_seq = '0;
      endcase
   end

   assign ok = (need > pos) && cont_good && !(complete && cp_seq > MAX_CP);

   always_comb begin
      held_cnt_next   = held_cnt;
      held_bytes_next = held_bytes;
      job.rep_cnt     = 3'd0;
      job.has_cp      = 1'b0;
      job.cp          = cp_seq;
      fresh           = (held_cnt == 2'd0);

      if (held_cnt != 2'd0) begin
         if (ok && complete) begin
            job.has_cp    = 1'b1;
            held_cnt_next = 2'd0;
         end else if (ok) begin
            held_bytes_next[held_cnt] = data_byte;
            held_cnt_next             = held_cnt + 2'd1;
            if (end_of_text) begin
               job.rep_cnt   = pos + 3'd1;
               held_cnt_next = 2'd0;
            end
         end else begin
            // flush what was held, then take this byte as a new start
            job.rep_cnt   = pos;
            held_cnt_next = 2'd0;
            fresh         = 1'b1;
         end
      end

      if (fresh) begin
         if (!data_byte[7]) begin
            job.has_cp = 1'b1;
            job.cp     = {13'd0, data_byte};
         end else if (seq_need(data_byte) != 3'd0) begin
            held_bytes_next[0] = data_byte;
            held_cnt_next      = 2'd1;
            if (end_of_text) begin
               job.rep_cnt   = job.rep_cnt + 3'd1;
               held_cnt_next = 2'd0;
            end
         end else begin
            job.rep_cnt = job.rep_cnt + 3'd1;
         end
      end

      job.con = console_form(job.cp);
   end

endmodule

[hdl/utf8_stream_decoder_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder_unit
// Strict utf-8 byte stream decoder with a console ascii form of each result.
// ----------------------------------------------------------------------------
// The req channel takes one byte per word with an end-of-text flag. The
// rsp channel gives code points, one per word: first any U+FFFD
// replacements the byte causes, then the decoded code point if one is
// finished. last_of_run marks the final word caused by a byte; a byte
// that only extends a held sequence gives no word at all.
// A byte is decoded in the cycle it is accepted and its words appear from
// the next cycle from the result register, one per cycle while rsp does
// not stall. A byte with k words (0 to 4) holds the result register until
// all k have left, so with no rsp stall the rate is one byte per cycle
// while each byte gives at most one word. req_stall rises only while the
// result register has words left that will not all leave this cycle; the
// next byte is taken in the same cycle as the last word of the previous one.
// A stall on rsp freezes the current word; decoding state is not touched.
// Reset clears the held count and the result register; held bytes are
// only read below the held count.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module utf8_stream_decoder_unit import utf8d_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_text,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [20:0] rsp_code_point,
   output logic        rsp_replaced,
   output logic [6:0]  rsp_console_char,
   output logic        rsp_last_of_run
);

   logic [1:0]      held_cnt_ff;
   logic [1:0]      held_cnt_in;
   logic [2:0][7:0] held_bytes_ff;
   logic [2:0][7:0] held_bytes_in;
   utf8d_job_type   dec_job;
   logic [2:0]      rep_ff;
   logic [2:0]      rep_in;
   logic            has_cp_ff;
   logic            has_cp_in;
   logic [20:0]     cp_ff;
   logic [20:0]     cp_in;
   logic [6:0]      con_ff;
   logic [6:0]      con_in;
   logic            req_accept;
   logic            rsp_fire;

   utf8d_decode u_decode (
      .data_byte       (req_data_byte),
      .end_of_text     (req_end_of_text),
      .held_cnt        (held_cnt_ff),
      .held_bytes      (held_bytes_ff),
      .held_cnt_next   (held_cnt_in),
      .held_bytes_next (held_bytes_in),
      .job             (dec_job)
   );

   assign rsp_valid        = (rep_ff != 3'd0) || has_cp_ff;
   assign rsp_replaced     = (rep_ff != 3'd0);
   assign rsp_code_point   = rsp_replaced ? REPL_CP : cp_ff;
   assign rsp_console_char = rsp_replaced ? CON_UNKNOWN : con_ff;
   assign rsp_last_of_run  = (rep_ff == 3'd0) || (rep_ff == 3'd1 && !has_cp_ff);
   assign rsp_fire         = rsp_valid && !rsp_stall;

   assign req_stall  = rsp_valid && !(rsp_fire && rsp_last_of_run);
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      rep_in    = rep_ff;
      has_cp_in = has_cp_ff;
      cp_in     = cp_ff;
      con_in    = con_ff;
      if (req_accept) begin
         rep_in    = dec_job.rep_cnt;
         has_cp_in = dec_job.has_cp;
         cp_in     = dec_job.cp;
         con_in    = dec_job.con;
      end else if (rsp_fire) begin
         if (rep_ff != 3'd0) begin
            rep_in = rep_ff - 3'd1;
         end else begin
            has_cp_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_cnt_ff <= 2'd0;
         rep_ff      <= 3'd0;
         has_cp_ff   <= 1'b0;
      end else begin
         if (req_accept) begin
            held_cnt_ff <= held_cnt_in;
         end
         rep_ff    <= rep_in;
         has_cp_ff <= has_cp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         held_bytes_ff <= held_bytes_in;
      end
      cp_ff  <= cp_in;
      con_ff <= con_in;
   end

   // a held sequence always starts with a lead that still needs more bytes
   `UTF8D_ASSERT_RST(a_held_lead, clock, reset, held_cnt_ff != 2'd0 |-> seq_need(held_bytes_ff[0]) > {1'b0, held_cnt_ff})

   // end of text never leaves a partial sequence behind
   `UTF8D_ASSERT_RST(a_eot_flush, clock, reset, req_accept && req_end_of_text |=> held_cnt_ff == 2'd0)

   // a decoded code point is always the final word of its byte
   `UTF8D_ASSERT_RST(a_cp_last, clock, reset, rsp_valid && !rsp_replaced |-> rsp_last_of_run)

   // result register is empty right after reset
   `UTF8D_ASSERT(a_reset_empty, clock, $past(reset) |-> !rsp_valid && held_cnt_ff == 2'd0)

endmodule
